### design/pfgr_pkg.sv
// Shared types, request codes and the 8x16 glyph ROM for the page framebuffer renderer.
// No dependencies.
package pfgr_pkg;

  // Store geometry
  localparam int STORE_DEPTH  = 1024;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int GLYPH_SPACE  = 14;

  // Request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_GLYPH = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pix_x;
    logic [7:0] pix_y;
    logic       pixel_on;
    logic [7:0] char_code;
    logic [9:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_byte;
  } out_item_t;

  // Store port request, sequencer to memory
  typedef struct packed {
    logic                re;
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          wdata;
  } mem_req_t;

  // Glyph ROM: 16 glyphs x 16 bytes, column-major, bit 0 at the top.
  // Bytes 0..7 are the upper eight rows, bytes 8..15 the lower eight.
  localparam logic [7:0] GLYPH_ROM [0:255] = '{
    8'h00,8'hE0,8'h10,8'h08,8'h08,8'h10,8'hE0,8'h00,
    8'h00,8'h0F,8'h10,8'h20,8'h20,8'h10,8'h0F,8'h00,
    8'h00,8'h10,8'h10,8'hF8,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h20,8'h20,8'h3F,8'h20,8'h20,8'h00,8'h00,
    8'h00,8'h70,8'h08,8'h08,8'h08,8'h88,8'h70,8'h00,
    8'h00,8'h30,8'h28,8'h24,8'h22,8'h21,8'h30,8'h00,
    8'h00,8'h30,8'h08,8'h88,8'h88,8'h48,8'h30,8'h00,
    8'h00,8'h18,8'h20,8'h20,8'h20,8'h11,8'h0E,8'h00,
    8'h00,8'h00,8'hC0,8'h20,8'h10,8'hF8,8'h00,8'h00,
    8'h00,8'h07,8'h04,8'h24,8'h24,8'h3F,8'h24,8'h00,
    8'h00,8'hF8,8'h08,8'h88,8'h88,8'h08,8'h08,8'h00,
    8'h00,8'h19,8'h21,8'h20,8'h20,8'h11,8'h0E,8'h00,
    8'h00,8'hE0,8'h10,8'h88,8'h88,8'h18,8'h00,8'h00,
    8'h00,8'h0F,8'h11,8'h20,8'h20,8'h11,8'h0E,8'h00,
    8'h00,8'h38,8'h08,8'h08,8'hC8,8'h38,8'h08,8'h00,
    8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h70,8'h88,8'h08,8'h08,8'h88,8'h70,8'h00,
    8'h00,8'h1C,8'h22,8'h21,8'h21,8'h22,8'h1C,8'h00,
    8'h00,8'hE0,8'h10,8'h08,8'h08,8'h10,8'hE0,8'h00,
    8'h00,8'h00,8'h31,8'h22,8'h22,8'h11,8'h0F,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h30,8'h30,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h18,8'h24,8'h18,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'hE0,8'h10,8'h08,8'h08,8'h10,8'h20,8'h00,
    8'h00,8'h0F,8'h10,8'h20,8'h20,8'h10,8'h08,8'h00,
    8'h00,8'hF0,8'h08,8'h08,8'hF0,8'h00,8'hC0,8'h30,
    8'h00,8'h18,8'h26,8'h21,8'h1E,8'h02,8'h01,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'hC0,8'hC0,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h30,8'h30,8'h00,8'h00,8'h00
  };

  // Character code to glyph slot; unknown codes draw as space
  function automatic logic [3:0] glyph_index(input logic [7:0] code);
    logic [3:0] gi;
    gi = 4'(GLYPH_SPACE);
    case (code) inside
      [8'h30:8'h39]: gi = code[3:0];
      8'h2E:         gi = 4'd10;
      8'hB0:         gi = 4'd11;
      8'h43:         gi = 4'd12;
      8'h25:         gi = 4'd13;
      8'h20:         gi = 4'd14;
      8'h3A:         gi = 4'd15;
      default:       gi = 4'(GLYPH_SPACE);
    endcase
    return gi;
  endfunction

endpackage

### design/pfgr_store.sv
// Framebuffer store: 1024 x 8 single-port synchronous RAM with a registered read port.
// Depends on pfgr_pkg.
module pfgr_store
  import pfgr_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/pfgr_ctrl.sv
// Request sequencer: clear sweep, pixel and glyph read-modify-write, byte read.
// Depends on pfgr_pkg; drives the pfgr_store port.
module pfgr_ctrl
  import pfgr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int PAGE_COUNT    = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  in_item_t   in_req,
  output logic       busy,
  output logic       out_strobe,
  output out_item_t  out_res,
  output mem_req_t   mem_req,
  input  logic [7:0] mem_rdata
);

  localparam logic [8:0] WIDTH_L  = 9'(SCREEN_WIDTH);
  localparam logic [8:0] HEIGHT_L = 9'(SCREEN_HEIGHT);
  localparam logic [5:0] PAGES_L  = 6'(PAGE_COUNT);
  localparam logic [15:0] DEPTH_L = 16'(STORE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_RD    = 5'b00100,
    S_WR    = 5'b01000,
    S_RBW   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [2:0]          col_r, col_nxt;
  logic [1:0]          pg_r, pg_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                report_r, report_nxt;
  logic [STORE_AW-1:0] addr_r, addr_nxt;
  logic                ok_r, ok_nxt;
  logic [7:0]          set_r, set_nxt;
  logic [7:0]          clr_r, clr_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  out_item_t           out_r, out_nxt;

  // Step address and bit masks
  logic        glyph_mode;
  logic [3:0]  gi;
  logic [15:0] gcol;
  logic [23:0] gshift;
  logic [7:0]  gbyte;
  logic [8:0]  px;
  logic [5:0]  page;
  logic [7:0]  bits;
  logic [7:0]  rowmask;
  logic [15:0] addr_full;
  logic [7:0]  hit;
  logic        step_ok;
  logic        accept;

  assign accept     = start && (state_r == S_IDLE);
  assign glyph_mode = (item_r.req_type == REQ_GLYPH);
  assign gi         = glyph_index(item_r.char_code);
  assign gcol       = {GLYPH_ROM[{gi, 1'b1, col_r}], GLYPH_ROM[{gi, 1'b0, col_r}]};
  assign gshift     = {8'd0, gcol} << item_r.pix_y[2:0];

  always_comb begin
    case (pg_r)
      2'd0:    gbyte = gshift[7:0];
      2'd1:    gbyte = gshift[15:8];
      default: gbyte = gshift[23:16];
    endcase
  end

  assign px   = {1'b0, item_r.pix_x} + (glyph_mode ? {6'd0, col_r} : 9'd0);
  assign page = {1'b0, item_r.pix_y[7:3]} + (glyph_mode ? {4'd0, pg_r} : 6'd0);
  assign bits = glyph_mode ? gbyte : (8'd1 << item_r.pix_y[2:0]);

  // Rows below the screen bottom are dropped bit by bit
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      rowmask[b] = ({page, 3'(b)} < HEIGHT_L);
    end
  end

  assign addr_full = {7'd0, px} + 16'(page) * 16'(WIDTH_L);
  assign hit       = bits & rowmask;
  assign step_ok   = (px < WIDTH_L) && (page < PAGES_L) && (addr_full < DEPTH_L) && (|hit);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    col_nxt        = col_r;
    pg_nxt         = pg_r;
    clr_cnt_nxt    = clr_cnt_r;
    report_nxt     = report_r;
    addr_nxt       = addr_r;
    ok_nxt         = ok_r;
    set_nxt        = set_r;
    clr_nxt        = clr_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    mem_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_req;
          col_nxt  = '0;
          pg_nxt   = '0;
          unique case (in_req.req_type)
            REQ_CLEAR: begin
              clr_cnt_nxt = '0;
              report_nxt  = 1'b1;
              state_nxt   = S_CLEAR;
            end
            REQ_READ: begin
              mem_req.re   = 1'b1;
              mem_req.addr = in_req.byte_index[STORE_AW-1:0];
              state_nxt    = S_RBW;
            end
            default: begin
              state_nxt = S_RD;
            end
          endcase
        end
      end
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt_r;
        mem_req.wdata = 8'd0;
        clr_cnt_nxt   = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt      = S_IDLE;
          out_strobe_nxt = report_r;
          out_nxt        = '0;
        end
      end
      S_RD: begin
        mem_req.re   = 1'b1;
        mem_req.addr = addr_full[STORE_AW-1:0];
        addr_nxt     = addr_full[STORE_AW-1:0];
        ok_nxt       = step_ok;
        set_nxt      = (glyph_mode || item_r.pixel_on) ? hit : 8'd0;
        clr_nxt      = (glyph_mode || item_r.pixel_on) ? 8'd0 : hit;
        state_nxt    = S_WR;
      end
      S_WR: begin
        mem_req.we    = ok_r;
        mem_req.addr  = addr_r;
        mem_req.wdata = (mem_rdata | set_r) & ~clr_r;
        if (!glyph_mode) begin
          state_nxt      = S_IDLE;
          out_strobe_nxt = 1'b1;
          out_nxt.status    = !ok_r;
          out_nxt.read_byte = 8'd0;
        end else if (pg_r == 2'd2) begin
          pg_nxt = '0;
          if (&col_r) begin
            state_nxt      = S_IDLE;
            out_strobe_nxt = 1'b1;
            out_nxt        = '0;
          end else begin
            col_nxt   = col_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          pg_nxt    = pg_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RBW: begin
        state_nxt         = S_IDLE;
        out_strobe_nxt    = 1'b1;
        out_nxt.status    = 1'b0;
        out_nxt.read_byte = mem_rdata;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      report_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      col_r        <= '0;
      pg_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      report_r     <= report_nxt;
      out_strobe_r <= out_strobe_nxt;
      col_r        <= col_nxt;
      pg_r         <= pg_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    addr_r <= addr_nxt;
    ok_r   <= ok_nxt;
    set_r  <= set_nxt;
    clr_r  <= clr_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;

endmodule

### design/page_framebuffer_glyph_renderer.sv
// Top level of the 128x64 page-layout framebuffer with 8x16 glyph renderer.
// Depends on pfgr_pkg, pfgr_store and pfgr_ctrl.
//
//  channel  ports                      transfer when
//  -------  -------------------------  ------------------------------
//  request  start, busy, in_req        start high and busy low
//  result   out_strobe, out_res        out_strobe high (one cycle)
//
// Work per request: read byte issues one store read; set pixel reads one
// store byte and writes it back; draw glyph visits 24 store bytes, each a read
// step then a write step on the single RAM port; clear writes one byte per cycle.
// After reset a clearing pass over all 1024 bytes runs with busy high.
// The result strobe follows the last cycle of work; busy drops at the same
// time, so the next request may be taken while the result is shown.
// The receiver cannot stall; results are never held back.
module page_framebuffer_glyph_renderer
  import pfgr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int PAGE_COUNT    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_req,
  output logic      out_strobe,
  output out_item_t out_res
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  // Sequencer
  pfgr_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .PAGE_COUNT    (PAGE_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req     (in_req),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  // Framebuffer RAM
  pfgr_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

### test/tb_top.sv
// Self-checking testbench for page_framebuffer_glyph_renderer: pixel, glyph, clear and read
// requests checked against a behavioural model of the 128x64 page-layout framebuffer.
// Depends on pfgr_pkg and the design sources.
`timescale 1ns / 1ps

module tb_top;
  import pfgr_pkg::*;

  // Screen geometry, as configured on the instance
  localparam int SCR_W = 128;
  localparam int SCR_H = 64;
  localparam int PAGES = 8;

  // Character codes with a glyph of their own, and one code without
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DEGREE  = 8'hB0;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UNKNOWN = 8'hFF;

  // Glyph slots of the non-digit characters
  localparam int SLOT_DOT     = 10;
  localparam int SLOT_DEGREE  = 11;
  localparam int SLOT_C       = 12;
  localparam int SLOT_PERCENT = 13;
  localparam int SLOT_SPACE   = 14;
  localparam int SLOT_COLON   = 15;

  localparam logic [7:0] DRAWN_CODES [0:15] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, CH_DOT, CH_DEGREE, CH_C, CH_PERCENT, CH_SPACE, CH_COLON
  };

  // Font: 16 glyphs of 16 bytes, column-major, bit 0 the top row of each half
  localparam logic [7:0] FONT [0:255] = '{
    8'h00,8'hE0,8'h10,8'h08,8'h08,8'h10,8'hE0,8'h00,
    8'h00,8'h0F,8'h10,8'h20,8'h20,8'h10,8'h0F,8'h00,
    8'h00,8'h10,8'h10,8'hF8,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h20,8'h20,8'h3F,8'h20,8'h20,8'h00,8'h00,
    8'h00,8'h70,8'h08,8'h08,8'h08,8'h88,8'h70,8'h00,
    8'h00,8'h30,8'h28,8'h24,8'h22,8'h21,8'h30,8'h00,
    8'h00,8'h30,8'h08,8'h88,8'h88,8'h48,8'h30,8'h00,
    8'h00,8'h18,8'h20,8'h20,8'h20,8'h11,8'h0E,8'h00,
    8'h00,8'h00,8'hC0,8'h20,8'h10,8'hF8,8'h00,8'h00,
    8'h00,8'h07,8'h04,8'h24,8'h24,8'h3F,8'h24,8'h00,
    8'h00,8'hF8,8'h08,8'h88,8'h88,8'h08,8'h08,8'h00,
    8'h00,8'h19,8'h21,8'h20,8'h20,8'h11,8'h0E,8'h00,
    8'h00,8'hE0,8'h10,8'h88,8'h88,8'h18,8'h00,8'h00,
    8'h00,8'h0F,8'h11,8'h20,8'h20,8'h11,8'h0E,8'h00,
    8'h00,8'h38,8'h08,8'h08,8'hC8,8'h38,8'h08,8'h00,
    8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h70,8'h88,8'h08,8'h08,8'h88,8'h70,8'h00,
    8'h00,8'h1C,8'h22,8'h21,8'h21,8'h22,8'h1C,8'h00,
    8'h00,8'hE0,8'h10,8'h08,8'h08,8'h10,8'hE0,8'h00,
    8'h00,8'h00,8'h31,8'h22,8'h22,8'h11,8'h0F,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h30,8'h30,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h18,8'h24,8'h18,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'hE0,8'h10,8'h08,8'h08,8'h10,8'h20,8'h00,
    8'h00,8'h0F,8'h10,8'h20,8'h20,8'h10,8'h08,8'h00,
    8'h00,8'hF0,8'h08,8'h08,8'hF0,8'h00,8'hC0,8'h30,
    8'h00,8'h18,8'h26,8'h21,8'h1E,8'h02,8'h01,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'hC0,8'hC0,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h30,8'h30,8'h00,8'h00,8'h00
  };

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      start      = 1'b0;
  in_item_t  in_req     = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_res;

  // Model of the store and the results still owed by the block
  logic [7:0] frame_model [0:STORE_DEPTH-1];
  out_item_t  pending_results [$];
  int         mismatches = 0;
  bit         burst_mode = 1'b0;

  page_framebuffer_glyph_renderer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  always #6 clk = ~clk;

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Pixel write into the model; returns 0 when the pixel is off the screen
  function automatic bit plot_pixel(int x, int y, bit lit);
    int a;
    if (x >= SCR_W || y >= SCR_H || (y >> 3) >= PAGES) return 1'b0;
    a = x + (y >> 3) * SCR_W;
    if (a >= STORE_DEPTH) return 1'b0;
    frame_model[a][y & 7] = lit;
    return 1'b1;
  endfunction

  function automatic int glyph_slot(logic [7:0] code);
    if (code >= CH_ZERO && code <= CH_NINE) return int'(code - CH_ZERO);
    case (code)
      CH_DOT:     return SLOT_DOT;
      CH_DEGREE:  return SLOT_DEGREE;
      CH_C:       return SLOT_C;
      CH_PERCENT: return SLOT_PERCENT;
      CH_COLON:   return SLOT_COLON;
      default:    return SLOT_SPACE;
    endcase
  endfunction

  // Applies one request to the model and gives the result it must produce
  function automatic out_item_t frame_apply(in_item_t it);
    out_item_t  res;
    int         slot;
    logic [7:0] bits;
    res = '0;
    case (it.req_type)
      REQ_CLEAR: begin
        for (int i = 0; i < STORE_DEPTH; i++) frame_model[i] = 8'h00;
      end
      REQ_PIXEL: begin
        res.status = !plot_pixel(int'(it.pix_x), int'(it.pix_y), it.pixel_on);
      end
      REQ_GLYPH: begin
        slot = glyph_slot(it.char_code);
        for (int col = 0; col < 8; col++) begin
          for (int row = 0; row < 16; row++) begin
            bits = FONT[slot * 16 + col + (row >> 3) * 8];
            // dark bits leave the store alone; lit ones off the screen are dropped
            if (bits[row & 7])
              void'(plot_pixel(int'(it.pix_x) + col, int'(it.pix_y) + row, 1'b1));
          end
        end
      end
      default: begin
        res.read_byte = frame_model[it.byte_index];
      end
    endcase
    return res;
  endfunction

  // Request of the given kind with every field random
  function automatic in_item_t noise_item(logic [1:0] kind);
    in_item_t it;
    it.req_type   = kind;
    it.pix_x      = 8'($urandom_range(0, 255));
    it.pix_y      = 8'($urandom_range(0, 255));
    it.pixel_on   = 1'($urandom_range(0, 1));
    it.char_code  = 8'($urandom_range(0, 255));
    it.byte_index = 10'($urandom_range(0, STORE_DEPTH - 1));
    return it;
  endfunction

  // One transfer on the request side, after a random gap unless in a burst
  task automatic send_request(input in_item_t it);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 4);
    else gap = $urandom_range(20, 90);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(frame_apply(it));
  endtask

  // Directed request; for a read, a is the byte address
  task automatic request(logic [1:0] kind, int a, int b, bit lit, logic [7:0] code);
    in_item_t it;
    it = noise_item(kind);
    if (kind == REQ_READ) begin
      it.byte_index = 10'(a);
    end else if (kind != REQ_CLEAR) begin
      it.pix_x     = 8'(a);
      it.pix_y     = 8'(b);
      it.pixel_on  = lit;
      it.char_code = code;
    end
    send_request(it);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: every strobe is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none expected: status %0b read_byte %02h",
                   $realtime, out_res.status, out_res.read_byte);
      end else begin
        want = pending_results.pop_front();
        if (out_res.status !== want.status || out_res.read_byte !== want.read_byte) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected status %0b read_byte %02h, got status %0b read_byte %02h",
                     $realtime, want.status, want.read_byte, out_res.status,
                     out_res.read_byte);
        end
      end
    end
  end

  // Store must read back as zero once the power-up clearing pass is done
  task automatic test_power_up_state();
    request(REQ_READ, 0, 0, 1'b0, 8'h00);
    request(REQ_READ, STORE_DEPTH - 1, 0, 1'b0, 8'h00);
  endtask

  // Corner pixels, clearing a pixel, and off-screen coordinates
  task automatic test_pixel_writes();
    request(REQ_PIXEL, 0, 0, 1'b1, 8'h00);
    request(REQ_PIXEL, SCR_W - 1, SCR_H - 1, 1'b1, 8'h00);
    request(REQ_READ, 0, 0, 1'b0, 8'h00);
    request(REQ_READ, STORE_DEPTH - 1, 0, 1'b0, 8'h00);
    request(REQ_PIXEL, 0, 0, 1'b0, 8'h00);
    request(REQ_READ, 0, 0, 1'b0, 8'h00);
    request(REQ_PIXEL, SCR_W, 0, 1'b1, 8'h00);
    request(REQ_PIXEL, 0, SCR_H, 1'b1, 8'h00);
    request(REQ_PIXEL, 255, 255, 1'b1, 8'h00);
  endtask

  // Aligned, unaligned, clipped and fully off-screen glyphs; unknown code draws blank
  task automatic test_glyph_render();
    request(REQ_GLYPH, 0, 0, 1'b0, 8'h38);
    request(REQ_READ, 1, 0, 1'b0, 8'h00);
    request(REQ_READ, SCR_W + 1, 0, 1'b0, 8'h00);
    request(REQ_GLYPH, SCR_W - 4, SCR_H - 8, 1'b0, CH_PERCENT);
    request(REQ_READ, STORE_DEPTH - 2, 0, 1'b0, 8'h00);
    request(REQ_GLYPH, 10, 10, 1'b0, CH_UNKNOWN);
    request(REQ_GLYPH, 255, 255, 1'b0, CH_COLON);
    request(REQ_GLYPH, 3, 5, 1'b0, CH_DEGREE);
  endtask

  // Clear issued with the pipeline empty, then read-back of drawn bytes
  task automatic test_clear_store();
    wait_results_drained();
    request(REQ_CLEAR, 0, 0, 1'b0, 8'h00);
    request(REQ_READ, SCR_W + 1, 0, 1'b0, 8'h00);
    request(REQ_READ, STORE_DEPTH - 1, 0, 1'b0, 8'h00);
  endtask

  // Mixed traffic, biased so reads land on bytes that have been drawn on
  task automatic test_random_traffic();
    in_item_t it;
    int       r;
    int       hot_base;
    hot_base = 0;
    for (int n = 0; n < 1080; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (n % 150 == 149) wait_results_drained();
      r = $urandom_range(0, 99);
      if (r < 2) begin
        it = noise_item(REQ_CLEAR);
      end else if (r < 32) begin
        it = noise_item(REQ_PIXEL);
        if ($urandom_range(0, 4) != 0) begin
          it.pix_x = 8'($urandom_range(0, SCR_W - 1));
          it.pix_y = 8'($urandom_range(0, SCR_H - 1));
        end
        it.pixel_on = ($urandom_range(0, 9) < 7);
      end else if (r < 62) begin
        it = noise_item(REQ_GLYPH);
        r = $urandom_range(0, 99);
        if (r < 75) begin
          it.pix_x = 8'($urandom_range(0, SCR_W - 8));
          it.pix_y = 8'($urandom_range(0, SCR_H - 16));
        end else if (r < 90) begin
          it.pix_x = 8'($urandom_range(SCR_W - 18, SCR_W + 12));
          it.pix_y = 8'($urandom_range(SCR_H - 24, SCR_H + 6));
        end
        if ($urandom_range(0, 9) < 7) it.char_code = DRAWN_CODES[$urandom_range(0, 15)];
      end else begin
        it = noise_item(REQ_READ);
        if ($urandom_range(0, 9) < 6)
          it.byte_index = 10'((hot_base + $urandom_range(0, 7) + $urandom_range(0, 2) * SCR_W)
                              % STORE_DEPTH);
      end
      // remember where drawing happened so reads can find it
      if (it.req_type inside {REQ_PIXEL, REQ_GLYPH} && it.pix_x < SCR_W && it.pix_y < SCR_H)
        hot_base = int'(it.pix_x) + (int'(it.pix_y) >> 3) * SCR_W;
      send_request(it);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_power_up_state();
    test_pixel_writes();
    test_glyph_render();
    test_clear_store();
    test_random_traffic();
    wait_results_drained();
    repeat (1100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
design/pfgr_pkg.sv
design/pfgr_store.sv
design/pfgr_ctrl.sv
design/page_framebuffer_glyph_renderer.sv
test/tb_top.sv
